// File: hw/rtl/smrf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smrf_pkg
// Types, register addresses and the attenuation table of the mixer register
// file.
// ----------------------------------------------------------------------------
package smrf_pkg;

	localparam int unsigned AddrW    = 8;
	localparam int unsigned MemDepth = 1 << AddrW;
	localparam int unsigned NumGain  = 6;
	localparam int unsigned NumPack  = 3;
	localparam int unsigned NumTone  = 4;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] gain_t;
	typedef logic [AddrW-1:0] addr_t;

	localparam logic OpWrite   = 1'b0;
	localparam logic OpRead    = 1'b1;
	localparam logic PortIndex = 1'b0;
	localparam logic PortData  = 1'b1;

	localparam addr_t RegVoice   = 8'h04;
	localparam addr_t RegStereo  = 8'h0E;
	localparam addr_t RegMaster  = 8'h22;
	localparam addr_t RegSynth   = 8'h26;
	localparam addr_t RegVolBase = 8'h30;
	localparam addr_t RegToneBase = 8'h44;
	localparam addr_t RegIrq     = 8'h80;
	localparam addr_t RegDma     = 8'h81;
	localparam addr_t RegStatus  = 8'h82;

	localparam byte_t DmaWord    = 8'h22;
	localparam byte_t PackedRst  = 8'hFF;
	localparam byte_t VolRst     = 8'hF8;
	localparam byte_t ToneRegRst = 8'h80;
	localparam byte_t ToneFlat   = 8'h88;
	localparam gain_t GainRst    = 16'hFFFF;

	localparam logic [1:0] Irq2  = 2'd0;
	localparam logic [1:0] Irq5  = 2'd1;
	localparam logic [1:0] Irq7  = 2'd2;
	localparam logic [1:0] Irq10 = 2'd3;

	// master, voice, synth
	localparam addr_t PackedAddr [NumPack] = '{RegMaster, RegVoice, RegSynth};

	typedef struct packed {
		logic  opcode;
		logic  port_select;
		byte_t write_data;
		logic  irq8_pending;
		logic  irq16_pending;
	} item_t;

	typedef struct packed {
		byte_t      read_data;
		gain_t      master_gain_left;
		gain_t      master_gain_right;
		gain_t      voice_gain_left;
		gain_t      voice_gain_right;
		gain_t      synth_gain_left;
		gain_t      synth_gain_right;
		byte_t      bass_levels;
		byte_t      treble_levels;
		logic       filter_enable;
		logic       stereo_enable;
		logic [1:0] irq_code;
	} result_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		byte_t wdata;
	} mem_wr_t;

	function automatic logic [4:0] packed_idx(input logic [3:0] nib);
		return {1'b1, nib[3:1], 1'b1};
	endfunction

	function automatic gain_t att_gain(input logic [4:0] idx);
		gain_t g;
		case (idx)
			5'd0:    g = 16'd310;
			5'd1:    g = 16'd368;
			5'd2:    g = 16'd437;
			5'd3:    g = 16'd520;
			5'd4:    g = 16'd618;
			5'd5:    g = 16'd735;
			5'd6:    g = 16'd873;
			5'd7:    g = 16'd1038;
			5'd8:    g = 16'd1234;
			5'd9:    g = 16'd1467;
			5'd10:   g = 16'd1743;
			5'd11:   g = 16'd2072;
			5'd12:   g = 16'd2463;
			5'd13:   g = 16'd2927;
			5'd14:   g = 16'd3479;
			5'd15:   g = 16'd4134;
			5'd16:   g = 16'd4914;
			5'd17:   g = 16'd5840;
			5'd18:   g = 16'd6941;
			5'd19:   g = 16'd8250;
			5'd20:   g = 16'd9805;
			5'd21:   g = 16'd11653;
			5'd22:   g = 16'd13850;
			5'd23:   g = 16'd16461;
			5'd24:   g = 16'd19564;
			5'd25:   g = 16'd23252;
			5'd26:   g = 16'd27635;
			5'd27:   g = 16'd32845;
			5'd28:   g = 16'd39036;
			5'd29:   g = 16'd46395;
			5'd30:   g = 16'd55140;
			default: g = 16'd65535;
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sound_card_mixer_register_file.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sound_card_mixer_register_file
// Pipeline: an accepted beat passes the input register, then the result
//   register, which drives the result beat.
// Throughput: one access per cycle while m_axis_tready stays high; a stalled
//   result beat holds the input register and drops s_axis_tready.
// Reset: asynchronous; the mixer layout resets to sixteen-bit mode and the
//   register store reads its reset values at once (valid bits, no sweep).
// ----------------------------------------------------------------------------
module sound_card_mixer_register_file (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic          cfg_data,        // mixer_mode
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire logic [15:0]   s_axis_tdata,    // write_data, irq8_pending, irq16_pending
	input  wire logic [1:0]    s_axis_tuser,    // opcode, port_select
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	output logic [127:0]       m_axis_tdata     // read_data, master L/R, voice L/R,
	                                            // synth L/R, bass_levels, treble_levels,
	                                            // filter_enable, stereo_enable, irq_code
);
	import smrf_pkg::*;

	logic    mode_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res;
	logic    adv;
	logic    accept;
	addr_t   index_n;
	mem_wr_t wr;
	byte_t   mem_byte;

	assign cfg_ready     = 1'b1;
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b1;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode        <= s_axis_tuser[0];
			item_s1.port_select   <= s_axis_tuser[1];
			item_s1.write_data    <= s_axis_tdata[7:0];
			item_s1.irq8_pending  <= s_axis_tdata[8];
			item_s1.irq16_pending <= s_axis_tdata[9];
		end
		if (adv) begin
			res_q <= res;
		end
	end

	smrf_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.raddr   (index_n),
		.wr      (wr),
		.rd_byte (mem_byte)
	);

	smrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.s1_valid (valid_s1),
		.item     (item_s1),
		.commit   (adv),
		.mem_byte (mem_byte),
		.index_n  (index_n),
		.wr       (wr),
		.res      (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		4'b0000,
		res_q.irq_code,
		res_q.stereo_enable,
		res_q.filter_enable,
		res_q.treble_levels,
		res_q.bass_levels,
		res_q.synth_gain_right,
		res_q.synth_gain_left,
		res_q.voice_gain_right,
		res_q.voice_gain_left,
		res_q.master_gain_right,
		res_q.master_gain_left,
		res_q.read_data
	};

endmodule
`default_nettype wire

// File: hw/rtl/smrf_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smrf_mem
// 256-byte register store with per-entry valid bits and a registered read
// port; bypasses a write that lands on the same edge as the read.
// ----------------------------------------------------------------------------
module smrf_mem (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            rd_en,
	input  wire smrf_pkg::addr_t raddr,
	input  wire smrf_pkg::mem_wr_t wr,
	output smrf_pkg::byte_t      rd_byte
);
	import smrf_pkg::*;

	byte_t                mem_q [MemDepth];
	logic [MemDepth-1:0]  vld_q;
	byte_t                rd_q;
	byte_t                fwd_data_q;
	logic                 fwd_q;
	logic                 vld_rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.wdata;
		end
		if (rd_en) begin
			rd_q       <= mem_q[raddr];
			fwd_data_q <= wr.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			fwd_q    <= 1'b0;
			vld_rd_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				fwd_q    <= wr.en && (wr.addr == raddr);
				vld_rd_q <= vld_q[raddr];
			end
		end
	end

	// never-written entries read as zero
	assign rd_byte = fwd_q ? fwd_data_q : (vld_rd_q ? rd_q : '0);

endmodule
`default_nettype wire

// File: hw/rtl/smrf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smrf_ctrl
// Index register, shadow copies of the mixer registers that feed the derived
// settings, gain and tone computation, and the read mux.
// ----------------------------------------------------------------------------
module smrf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              mode,
	input  wire logic              s1_valid,
	input  wire smrf_pkg::item_t   item,
	input  wire logic              commit,
	input  wire smrf_pkg::byte_t   mem_byte,
	output smrf_pkg::addr_t        index_n,
	output smrf_pkg::mem_wr_t      wr,
	output smrf_pkg::result_t      res
);
	import smrf_pkg::*;

	addr_t      index_q;
	byte_t      pk_q   [NumPack];
	byte_t      vol_q  [NumGain];
	byte_t      tone_q [NumTone];
	byte_t      e_q;
	gain_t      gain_q [NumGain];
	byte_t      bass_q;
	byte_t      treble_q;
	logic       filt_q;
	logic       stereo_q;
	logic [1:0] irq_q;

	byte_t      pk_n   [NumPack];
	byte_t      vol_n  [NumGain];
	byte_t      tone_n [NumTone];
	byte_t      e_n;
	gain_t      gain_n [NumGain];
	logic [4:0] gsel   [NumGain];
	byte_t      bass_n;
	byte_t      treble_n;
	logic       filt_n;
	logic       stereo_n;
	logic [1:0] irq_n;
	byte_t      rd;
	byte_t      shadow;
	logic       data_wr;
	logic       idx_wr;
	byte_t      wd;

	assign wd      = item.write_data;
	assign data_wr = s1_valid && (item.opcode == OpWrite) && (item.port_select == PortData);
	assign idx_wr  = s1_valid && (item.opcode == OpWrite) && (item.port_select == PortIndex);
	assign index_n = idx_wr ? wd : index_q;

	assign wr.en    = commit && data_wr;
	assign wr.addr  = index_q;
	assign wr.wdata = wd;

	always_comb begin
		for (int p = 0; p < NumPack; p++) begin
			pk_n[p] = (data_wr && index_q == PackedAddr[p]) ? wd : pk_q[p];
		end
		for (int i = 0; i < NumGain; i++) begin
			vol_n[i] = (data_wr && index_q == RegVolBase + addr_t'(i)) ? wd : vol_q[i];
		end
		// sixteen-bit layout mirrors packed writes into the channel pair
		for (int p = 0; p < NumPack; p++) begin
			if (data_wr && mode && index_q == PackedAddr[p]) begin
				vol_n[2*p]   = {packed_idx(wd[7:4]), 3'b000};
				vol_n[2*p+1] = {packed_idx(wd[3:0]), 3'b000};
			end
		end
		for (int t = 0; t < NumTone; t++) begin
			tone_n[t] = (data_wr && index_q == RegToneBase + addr_t'(t)) ? wd : tone_q[t];
		end
		e_n = (data_wr && index_q == RegStereo) ? wd : e_q;

		for (int p = 0; p < NumPack; p++) begin
			gsel[2*p]   = mode ? vol_n[2*p][7:3]   : packed_idx(pk_n[p][7:4]);
			gsel[2*p+1] = mode ? vol_n[2*p+1][7:3] : packed_idx(pk_n[p][3:0]);
		end
		for (int i = 0; i < NumGain; i++) begin
			gain_n[i] = data_wr ? att_gain(gsel[i]) : gain_q[i];
		end

		bass_n   = bass_q;
		treble_n = treble_q;
		filt_n   = filt_q;
		if (data_wr) begin
			bass_n   = mode ? {tone_n[2][7:4], tone_n[3][7:4]} : ToneFlat;
			treble_n = mode ? {tone_n[0][7:4], tone_n[1][7:4]} : ToneFlat;
			filt_n   = mode ? 1'b0 : !e_n[5];
		end
		stereo_n = (data_wr && !mode && index_q == RegStereo) ? wd[1] : stereo_q;

		irq_n = irq_q;
		if (data_wr && mode && index_q == RegIrq) begin
			if (wd[3]) begin
				irq_n = Irq10;
			end else if (wd[2]) begin
				irq_n = Irq7;
			end else if (wd[1]) begin
				irq_n = Irq5;
			end else if (wd[0]) begin
				irq_n = Irq2;
			end
		end
	end

	// shadowed registers are served from the copies, the rest from the store
	always_comb begin
		shadow = mem_byte;
		for (int p = 0; p < NumPack; p++) begin
			if (index_q == PackedAddr[p]) shadow = pk_q[p];
		end
		for (int i = 0; i < NumGain; i++) begin
			if (index_q == RegVolBase + addr_t'(i)) shadow = vol_q[i];
		end
		for (int t = 0; t < NumTone; t++) begin
			if (index_q == RegToneBase + addr_t'(t)) shadow = tone_q[t];
		end
		if (index_q == RegStereo) shadow = e_q;
	end

	always_comb begin
		rd = '0;
		if (s1_valid && item.opcode == OpRead) begin
			if (item.port_select == PortIndex) begin
				rd = index_q;
			end else if (mode && index_q == RegIrq) begin
				case (irq_q)
					Irq2:    rd = 8'h01;
					Irq5:    rd = 8'h02;
					Irq7:    rd = 8'h04;
					Irq10:   rd = 8'h08;
					default: rd = 8'h00;
				endcase
			end else if (mode && index_q == RegDma) begin
				rd = DmaWord;
			end else if (mode && index_q == RegStatus) begin
				rd = {6'b0, item.irq16_pending, item.irq8_pending};
			end else begin
				rd = shadow;
			end
		end
	end

	assign res.read_data         = rd;
	assign res.master_gain_left  = gain_n[0];
	assign res.master_gain_right = gain_n[1];
	assign res.voice_gain_left   = gain_n[2];
	assign res.voice_gain_right  = gain_n[3];
	assign res.synth_gain_left   = gain_n[4];
	assign res.synth_gain_right  = gain_n[5];
	assign res.bass_levels       = bass_n;
	assign res.treble_levels     = treble_n;
	assign res.filter_enable     = filt_n;
	assign res.stereo_enable     = stereo_n;
	assign res.irq_code          = irq_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q  <= '0;
			for (int p = 0; p < NumPack; p++) pk_q[p] <= PackedRst;
			for (int i = 0; i < NumGain; i++) begin
				vol_q[i]  <= VolRst;
				gain_q[i] <= GainRst;
			end
			for (int t = 0; t < NumTone; t++) tone_q[t] <= ToneRegRst;
			e_q      <= '0;
			bass_q   <= ToneFlat;
			treble_q <= ToneFlat;
			filt_q   <= 1'b1;
			stereo_q <= 1'b0;
			irq_q    <= Irq7;
		end else if (commit) begin
			index_q  <= index_n;
			for (int p = 0; p < NumPack; p++) pk_q[p] <= pk_n[p];
			for (int i = 0; i < NumGain; i++) begin
				vol_q[i]  <= vol_n[i];
				gain_q[i] <= gain_n[i];
			end
			for (int t = 0; t < NumTone; t++) tone_q[t] <= tone_n[t];
			e_q      <= e_n;
			bass_q   <= bass_n;
			treble_q <= treble_n;
			filt_q   <= filt_n;
			stereo_q <= stereo_n;
			irq_q    <= irq_n;
		end
	end

endmodule
`default_nettype wire
